FILE: src/asv_pkg.sv
// Shared types and constants for the ADSR sine synth voice.
// No dependencies; imported by the divider, datapath, controller and top level.
`default_nettype none
package asv_pkg;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_NOTE_ON  = 2'd1,
        CMD_NOTE_OFF = 2'd2,
        CMD_ALL_OFF  = 2'd3
    } t_cmd;

    localparam logic [1:0] VS_OFF      = 2'd0;
    localparam logic [1:0] VS_PRESSED  = 2'd1;
    localparam logic [1:0] VS_RELEASED = 2'd2;

    localparam logic [2:0] REG_ATTACK  = 3'd0;
    localparam logic [2:0] REG_DECAY   = 3'd1;
    localparam logic [2:0] REG_SUSTAIN = 3'd2;
    localparam logic [2:0] REG_RELEASE = 3'd3;
    localparam logic [2:0] REG_GAIN    = 3'd4;

    localparam int DIV_NW = 40;
    localparam int DIV_DW = 20;

    localparam logic [15:0] FULL_SCALE = 16'd32768;
    localparam logic [23:0] TIME_MAX   = 24'hFFFFFF;

    // ceil(2^29 / 127): floor(n * OUT_RECIP >> 29) equals n / 127 for n < 2^22
    localparam logic [31:0] OUT_RECIP   = 32'd4227331;
    localparam int          RECIP_SHIFT = 29;

    // Quarter-wave sine polynomial coefficients, Q30
    localparam logic [31:0] POLY_C9 = 32'd172272;
    localparam logic [31:0] POLY_C7 = 32'd5026995;
    localparam logic [31:0] POLY_C5 = 32'd85569306;
    localparam logic [31:0] POLY_C3 = 32'd693598668;
    localparam logic [31:0] POLY_C1 = 32'd1686629713;
    localparam logic [30:0] Q30_ONE = 31'h40000000;

    // Frequencies of notes 120..131 in Hz, Q16.16
    localparam logic [31:0] TOP_OCT_Q16 [12] = '{
        32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
        32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
        32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
    };

    typedef struct packed {
        logic [19:0] attack_len;
        logic [19:0] decay_len;
        logic [15:0] sus_level;
        logic [19:0] rel_len;
        logic [15:0] out_gain;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_ENV_SEL, OP_ENV_DIV, OP_ENV_FIN,
        OP_NOTE_ON, OP_NOTE_OFF, OP_ALL_OFF,
        OP_SIN_X, OP_M_XX, OP_X2, OP_M_P1, OP_P1, OP_M_P, OP_P2, OP_P3, OP_P4,
        OP_M_XP, OP_SIN, OP_M_ES, OP_A, OP_M_VG, OP_M_AB, OP_M_RCP, OP_RESULT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic env_div;
        logic off_hit;
        logic div_busy;
    } t_stat;

    // Octave of a MIDI note (note / 12) by compares
    function automatic logic [3:0] note_octave(input logic [6:0] note);
        logic [3:0] oct;
        oct = 4'd0;
        for (int j = 1; j <= 10; j++) begin
            if (note >= 7'(12 * j)) oct = 4'(j);
        end
        return oct;
    endfunction

endpackage
`default_nettype wire

FILE: src/adsr_sine_synth_voice.sv
// Monophonic ADSR-enveloped sine voice: ties the APB register file,
// controller asv_ctrl and datapath asv_datapath together. Depends on asv_pkg.
//
// Usage:
//   Command channel (i_valid/o_ready): tick, note on, note off, all-off.
//   Result channel (o_valid/i_ready): one sample beat per tick, none otherwise.
//   Registers at byte addresses 0,4,8,12,16: attack, decay, sustain,
//   release, gain. Write them only while the voice is idle.
// Timing:
//   One command at a time. A tick steps through decode, segment select,
//   a 40-step pass of the shared radix-2 divider and 3 steps around it
//   while the envelope is on a slope, 17 multiplier and sine steps, one
//   reciprocal multiply for the /127 output scale and the output load.
//   Note on and a matching note off run decode, segment select, the
//   divider pass on a slope and their voice update; all-off and an
//   unmatched note off end at decode. The output register decouples
//   the two sides: a new command is taken while a sample beat waits; a tick
//   stalls only in its last step until the previous beat is taken.
// Reset: synchronous, active low; voice off, phase zero, registers at
//   their defaults, no beat pending.
`default_nettype none
module adsr_sine_synth_voice #(
    parameter int SAMPLE_RATE      = 48000,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [6:0]  i_note,
    input  wire logic [6:0]  i_velocity,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [15:0] o_sample,
    output logic [1:0]       o_voice_phase
);
    import asv_pkg::*;

    t_cfg       r_cfg;
    t_ctl       ctl;
    t_stat      stat;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_len <= 20'd480;
            r_cfg.decay_len  <= 20'd4800;
            r_cfg.sus_level  <= 16'd16384;
            r_cfg.rel_len    <= 20'd4800;
            r_cfg.out_gain   <= 16'd32768;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ATTACK:  r_cfg.attack_len <= pwdata[19:0];
                REG_DECAY:   r_cfg.decay_len  <= pwdata[19:0];
                REG_SUSTAIN: r_cfg.sus_level  <= pwdata[15:0];
                REG_RELEASE: r_cfg.rel_len    <= pwdata[19:0];
                REG_GAIN:    r_cfg.out_gain   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ATTACK:  prdata = 32'(r_cfg.attack_len);
            REG_DECAY:   prdata = 32'(r_cfg.decay_len);
            REG_SUSTAIN: prdata = 32'(r_cfg.sus_level);
            REG_RELEASE: prdata = 32'(r_cfg.rel_len);
            REG_GAIN:    prdata = 32'(r_cfg.out_gain);
            default:     prdata = '0;
        endcase
    end

    asv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    asv_datapath #(
        .SAMPLE_RATE      (SAMPLE_RATE),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .PHASE_BITS       (PHASE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_command     (i_command),
        .i_note        (i_note),
        .i_velocity    (i_velocity),
        .i_ctl         (ctl),
        .o_stat        (stat),
        .o_sample      (o_sample),
        .o_voice_phase (o_voice_phase)
    );

endmodule
`default_nettype wire

FILE: src/asv_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on asv_pkg for operand widths.
`default_nettype none
module asv_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [asv_pkg::DIV_NW-1:0] i_num,
    input  wire logic [asv_pkg::DIV_DW-1:0] i_den,
    output logic                           o_busy,
    output logic [asv_pkg::DIV_NW-1:0]      o_quo
);
    import asv_pkg::*;

    localparam int CW = $clog2(DIV_NW + 1);

    logic              r_busy;
    logic [CW-1:0]     r_cnt;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW:0]   shifted;
    logic              fits;

    always_comb begin
        shifted = {r_rem, r_quo[DIV_NW-1]};
        fits    = shifted >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DIV_NW);
            r_den  <= i_den;
            r_rem  <= '0;
            r_quo  <= i_num;
        end else if (r_busy) begin
            r_rem  <= fits ? DIV_DW'(shifted - {1'b0, r_den}) : DIV_DW'(shifted);
            r_quo  <= {r_quo[DIV_NW-2:0], fits};
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= r_cnt != CW'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider not busy after start");

endmodule
`default_nettype wire

FILE: src/asv_datapath.sv
// Voice state, envelope and sine datapath with one shared multiplier and divider.
// Depends on asv_pkg and asv_div; driven by asv_ctrl through t_ctl / t_stat.
`default_nettype none
module asv_datapath #(
    parameter int SAMPLE_RATE      = 48000,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire asv_pkg::t_cfg     i_cfg,
    input  wire logic [1:0]        i_command,
    input  wire logic [6:0]        i_note,
    input  wire logic [6:0]        i_velocity,
    input  wire asv_pkg::t_ctl     i_ctl,
    output asv_pkg::t_stat         o_stat,
    output logic signed [15:0]     o_sample,
    output logic [1:0]             o_voice_phase
);
    import asv_pkg::*;

    localparam int IW = $clog2(SINE_TABLE_DEPTH);

    localparam logic [63:0] STEP_TOP [12] = '{
        (64'(TOP_OCT_Q16[0])  << PHASE_BITS) / SAMPLE_RATE,
        (64'(TOP_OCT_Q16[1])  << PHASE_BITS) / SAMPLE_RATE,
        (64'(TOP_OCT_Q16[2])  << PHASE_BITS) / SAMPLE_RATE,
        (64'(TOP_OCT_Q16[3])  << PHASE_BITS) / SAMPLE_RATE,
        (64'(TOP_OCT_Q16[4])  << PHASE_BITS) / SAMPLE_RATE,
        (64'(TOP_OCT_Q16[5])  << PHASE_BITS) / SAMPLE_RATE,
        (64'(TOP_OCT_Q16[6])  << PHASE_BITS) / SAMPLE_RATE,
        (64'(TOP_OCT_Q16[7])  << PHASE_BITS) / SAMPLE_RATE,
        (64'(TOP_OCT_Q16[8])  << PHASE_BITS) / SAMPLE_RATE,
        (64'(TOP_OCT_Q16[9])  << PHASE_BITS) / SAMPLE_RATE,
        (64'(TOP_OCT_Q16[10]) << PHASE_BITS) / SAMPLE_RATE,
        (64'(TOP_OCT_Q16[11]) << PHASE_BITS) / SAMPLE_RATE
    };

    // voice state
    logic [1:0]            r_status;
    logic [6:0]            r_note;
    logic [6:0]            r_vel;
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] r_step;
    logic [23:0]           r_time;
    logic [15:0]           r_start;

    // latched command
    t_cmd                  r_cmd;
    logic [6:0]            r_in_note;
    logic [6:0]            r_in_vel;

    // work registers
    logic [63:0]           r_mul;
    logic [15:0]           r_env;
    logic [15:0]           r_base;
    logic                  r_sub;
    logic [19:0]           r_den;
    logic [30:0]           r_x;
    logic [30:0]           r_x2;
    logic [30:0]           r_p;
    logic [1:0]            r_quad;
    logic [14:0]           r_sin;
    logic                  r_neg;
    logic [30:0]           r_a;
    logic signed [15:0]    r_out_sample;
    logic [1:0]            r_out_phase;

    logic [15:0]           sus_sat;
    logic [15:0]           gain_sat;
    logic [15:0]           start_sat;
    logic                  env_div;
    logic [15:0]           env_const;
    logic [15:0]           e_coef;
    logic [23:0]           e_tm;
    logic [19:0]           e_den;
    logic [15:0]           e_base;
    logic                  e_sub;

    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic                  mul_en;

    logic                  div_start;
    logic [DIV_NW-1:0]     div_num;
    logic [DIV_DW-1:0]     div_den;
    logic                  div_busy;
    logic [DIV_NW-1:0]     div_q;

    logic [3:0]            oct;
    logic [3:0]            semi;
    logic [63:0]           step_full;
    logic [IW-1:0]         sin_idx;
    logic [31:0]           sin_t;
    logic [29:0]           sin_r;
    logic [32:0]           sin_round;
    logic [17:0]           sin_m;
    logic [14:0]           out_mag;
    logic [23:0]           time_n;

    // envelope segment selection
    always_comb begin
        sus_sat   = (i_cfg.sus_level > FULL_SCALE) ? FULL_SCALE : i_cfg.sus_level;
        gain_sat  = (i_cfg.out_gain > FULL_SCALE) ? FULL_SCALE : i_cfg.out_gain;
        start_sat = (r_start > FULL_SCALE) ? FULL_SCALE : r_start;
        env_div   = 1'b0;
        env_const = '0;
        e_coef    = '0;
        e_tm      = '0;
        e_den     = '0;
        e_base    = '0;
        e_sub     = 1'b0;
        case (r_status)
            VS_PRESSED: begin
                if (r_time < 24'(i_cfg.attack_len)) begin
                    env_div = 1'b1;
                    e_coef  = FULL_SCALE - start_sat;
                    e_tm    = r_time;
                    e_den   = i_cfg.attack_len;
                    e_base  = start_sat;
                end else if (25'(r_time) < 25'(i_cfg.attack_len) + 25'(i_cfg.decay_len)) begin
                    env_div = 1'b1;
                    e_coef  = FULL_SCALE - sus_sat;
                    e_tm    = r_time - 24'(i_cfg.attack_len);
                    e_den   = i_cfg.decay_len;
                    e_base  = FULL_SCALE;
                    e_sub   = 1'b1;
                end else begin
                    env_const = sus_sat;
                end
            end
            VS_RELEASED: begin
                if (r_time < 24'(i_cfg.rel_len)) begin
                    env_div = 1'b1;
                    e_coef  = start_sat;
                    e_tm    = r_time;
                    e_den   = i_cfg.rel_len;
                    e_base  = start_sat;
                    e_sub   = 1'b1;
                end
            end
            default: env_const = '0;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (i_ctl.op)
            OP_ENV_SEL: begin mul_a = 32'(e_coef); mul_b = 32'(e_tm);     end
            OP_M_XX:    begin mul_a = 32'(r_x);    mul_b = 32'(r_x);      end
            OP_M_P1:    begin mul_a = 32'(r_x2);   mul_b = POLY_C9;       end
            OP_M_P:     begin mul_a = 32'(r_x2);   mul_b = 32'(r_p);      end
            OP_M_XP:    begin mul_a = 32'(r_x);    mul_b = 32'(r_p);      end
            OP_M_ES:    begin mul_a = 32'(r_env);  mul_b = 32'(r_sin);    end
            OP_M_VG:    begin mul_a = 32'(r_vel);  mul_b = 32'(gain_sat); end
            OP_M_AB:    begin mul_a = 32'(r_a);    mul_b = 32'(r_mul[22:0]); end
            // scale by 1/127 on the product already shifted down by 30
            OP_M_RCP:   begin mul_a = 32'(r_mul[53:30]); mul_b = OUT_RECIP; end
            default:    mul_en = 1'b0;
        endcase
    end

    always_comb begin
        div_start = (i_ctl.op == OP_ENV_DIV);
        div_num   = r_mul[DIV_NW-1:0];
        div_den   = r_den;
    end

    asv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_q)
    );

    always_comb begin
        oct       = note_octave(r_in_note);
        semi      = 4'(r_in_note - 7'(7'(oct) * 7'd12));
        step_full = STEP_TOP[semi] >> (5'd26 - 5'(oct));
        sin_idx   = r_phase[PHASE_BITS-1 -: IW];
        sin_t     = {sin_idx, (32-IW)'(0)};
        sin_r     = sin_t[29:0];
        sin_round = 33'(r_mul >> 30) + 33'd16384;
        sin_m     = 18'(sin_round >> 15);
        out_mag   = ((r_mul >> RECIP_SHIFT) > 64'd32767) ? 15'h7FFF
                                                         : r_mul[RECIP_SHIFT +: 15];
        time_n    = (r_time == TIME_MAX) ? r_time : r_time + 24'd1;
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) r_mul <= 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= VS_OFF;
            r_note   <= '0;
            r_vel    <= '0;
            r_phase  <= '0;
            r_step   <= '0;
            r_time   <= '0;
            r_start  <= '0;
        end else begin
            case (i_ctl.op)
                OP_LOAD: begin
                    r_cmd     <= t_cmd'(i_command);
                    r_in_note <= i_note;
                    r_in_vel  <= i_velocity;
                end
                OP_ENV_SEL: begin
                    r_env  <= env_const;
                    r_base <= e_base;
                    r_sub  <= e_sub;
                    r_den  <= e_den;
                end
                OP_ENV_FIN: begin
                    r_env <= r_sub ? r_base - div_q[15:0] : r_base + div_q[15:0];
                end
                OP_NOTE_ON: begin
                    r_start  <= r_env;
                    r_note   <= r_in_note;
                    r_vel    <= r_in_vel;
                    r_step   <= step_full[PHASE_BITS-1:0];
                    r_status <= VS_PRESSED;
                    r_time   <= '0;
                end
                OP_NOTE_OFF: begin
                    r_start <= r_env;
                    r_time  <= '0;
                    if (i_cfg.rel_len == '0) begin
                        r_status <= VS_OFF;
                        r_phase  <= '0;
                    end else begin
                        r_status <= VS_RELEASED;
                    end
                end
                OP_ALL_OFF: begin
                    r_status <= VS_OFF;
                    r_phase  <= '0;
                end
                OP_SIN_X: begin
                    r_quad <= sin_t[31:30];
                    r_x    <= sin_t[30] ? Q30_ONE - 31'(sin_r) : 31'(sin_r);
                end
                OP_X2: r_x2 <= 31'(r_mul >> 30);
                OP_P1: r_p  <= 31'(64'(POLY_C7) - (r_mul >> 30));
                OP_P2: r_p  <= 31'(64'(POLY_C5) - (r_mul >> 30));
                OP_P3: r_p  <= 31'(64'(POLY_C3) - (r_mul >> 30));
                OP_P4: r_p  <= 31'(64'(POLY_C1) - (r_mul >> 30));
                OP_SIN: begin
                    r_sin <= (sin_m > 18'd32767) ? 15'h7FFF : sin_m[14:0];
                    r_neg <= r_quad[1];
                end
                OP_A: r_a <= r_mul[30:0];
                OP_RESULT: begin
                    r_out_sample <= r_neg ? -$signed({1'b0, out_mag}) : $signed({1'b0, out_mag});
                    r_out_phase  <= r_status;
                    r_time       <= time_n;
                    // release ends on the advanced time
                    if (r_status == VS_RELEASED && time_n >= 24'(i_cfg.rel_len)) begin
                        r_status <= VS_OFF;
                        r_phase  <= '0;
                    end else begin
                        r_phase <= r_phase + r_step;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.cmd      = r_cmd;
        o_stat.env_div  = env_div;
        o_stat.off_hit  = (r_status == VS_PRESSED) && (r_note == r_in_note);
        o_stat.div_busy = div_busy;
    end

    assign o_sample      = r_out_sample;
    assign o_voice_phase = r_out_phase;

    a_all_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == OP_ALL_OFF) |=> (r_status == VS_OFF && r_phase == '0))
        else $error("all-off did not silence the voice");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_status != 2'b11)
        else $error("voice status holds an unused code");

endmodule
`default_nettype wire

FILE: src/asv_ctrl.sv
// Sequencer for the voice: walks the datapath through envelope, sine and output steps.
// Depends on asv_pkg for the op codes and the command/status structs.
`default_nettype none
module asv_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire asv_pkg::t_stat i_stat,
    output asv_pkg::t_ctl       o_ctl
);
    import asv_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_ENV_SEL, S_ENV_DIV, S_ENV_WAIT, S_ENV_FIN,
        S_NOTE_ON, S_NOTE_OFF,
        S_SIN_X, S_M_XX, S_X2, S_M_P1, S_P1, S_M_P2, S_P2, S_M_P3, S_P3,
        S_M_P4, S_P4, S_M_XP, S_SIN, S_M_ES, S_A, S_M_VG, S_M_AB,
        S_M_RCP, S_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_op    op;
    t_state after_env;

    always_comb begin
        case (i_stat.cmd)
            CMD_TICK:    after_env = S_SIN_X;
            CMD_NOTE_ON: after_env = S_NOTE_ON;
            default:     after_env = S_NOTE_OFF;
        endcase
    end

    always_comb begin
        op      = OP_NONE;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.cmd == CMD_ALL_OFF) begin
                    op      = OP_ALL_OFF;
                    n_state = S_IDLE;
                end else if (i_stat.cmd == CMD_NOTE_OFF && !i_stat.off_hit) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ENV_SEL;
                end
            end
            S_ENV_SEL: begin
                op      = OP_ENV_SEL;
                n_state = i_stat.env_div ? S_ENV_DIV : after_env;
            end
            S_ENV_DIV:  begin op = OP_ENV_DIV; n_state = S_ENV_WAIT; end
            S_ENV_WAIT: if (!i_stat.div_busy) n_state = S_ENV_FIN;
            S_ENV_FIN:  begin op = OP_ENV_FIN;  n_state = after_env; end
            S_NOTE_ON:  begin op = OP_NOTE_ON;  n_state = S_IDLE; end
            S_NOTE_OFF: begin op = OP_NOTE_OFF; n_state = S_IDLE; end
            S_SIN_X:    begin op = OP_SIN_X;    n_state = S_M_XX; end
            S_M_XX:     begin op = OP_M_XX;     n_state = S_X2; end
            S_X2:       begin op = OP_X2;       n_state = S_M_P1; end
            S_M_P1:     begin op = OP_M_P1;     n_state = S_P1; end
            S_P1:       begin op = OP_P1;       n_state = S_M_P2; end
            S_M_P2:     begin op = OP_M_P;      n_state = S_P2; end
            S_P2:       begin op = OP_P2;       n_state = S_M_P3; end
            S_M_P3:     begin op = OP_M_P;      n_state = S_P3; end
            S_P3:       begin op = OP_P3;       n_state = S_M_P4; end
            S_M_P4:     begin op = OP_M_P;      n_state = S_P4; end
            S_P4:       begin op = OP_P4;       n_state = S_M_XP; end
            S_M_XP:     begin op = OP_M_XP;     n_state = S_SIN; end
            S_SIN:      begin op = OP_SIN;      n_state = S_M_ES; end
            S_M_ES:     begin op = OP_M_ES;     n_state = S_A; end
            S_A:        begin op = OP_A;        n_state = S_M_VG; end
            S_M_VG:     begin op = OP_M_VG;     n_state = S_M_AB; end
            S_M_AB:     begin op = OP_M_AB;     n_state = S_M_RCP; end
            S_M_RCP:    begin op = OP_M_RCP;    n_state = S_RESULT; end
            S_RESULT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    op      = OP_RESULT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (op == OP_RESULT) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_ctl.op    = op;

    a_env_fin_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENV_FIN) |-> !i_stat.div_busy)
        else $error("envelope finished while divider busy");

    a_result_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && (!r_out_valid || i_out_ready)) |=> r_out_valid)
        else $error("result not presented");

endmodule
`default_nettype wire
